// File: rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Transaction types, action codes and round constants shared by the hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned NUM_ROUNDS = 80;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [31:0] IV [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

endpackage

// File: rtl/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Absorbs a message one byte per transaction and emits its 160-bit digest.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in): each transaction carries an
// action and a byte. Absorb appends the byte; finish pads the message, appends
// the 64-bit bit length and emits the digest on the output channel
// (o_out_valid / i_out_ready / o_out) as five big-endian words, H0 first, the
// fifth flagged last_word. The hasher then starts a new message.
// An absorb that completes a 64-byte block starts a compression: one load,
// 80 rounds on a single round unit, one chaining add; the input side is not
// ready until it ends. A finish writes padding and length one byte per cycle
// up to the end of the block, compresses once or twice, then hands out one
// word per cycle while the receiver takes them. A stalled receiver holds the
// word in the output register and stalls the digest sequence; the input
// side is not ready from a finish until the fifth word is loaded. Reset
// loads the initial chaining values and clears the byte counters; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module sha1_stream_hasher
    import sha1_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LEN   = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_COMP  = 3'd4;
    localparam logic [2:0] ST_ADD   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);
    localparam logic [2:0] LAST_WORD  = 3'(NUM_WORDS - 1);

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_ret, n_ret;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_total, n_total;
    logic [6:0]  r_rnd, n_rnd;
    logic [2:0]  r_widx, n_widx;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_h [NUM_WORDS];
    logic [31:0] n_h [NUM_WORDS];

    logic [31:0] r_w [16];
    logic [31:0] n_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic [63:0] r_len, n_len;
    t_out        r_out, n_out;

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [31:0] f_val, k_val, t_val, w_new;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_comb begin
        if (r_rnd < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_0;
        end else if (r_rnd < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_1;
        end else if (r_rnd < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_3;
        end
        t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];
        w_new = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_fill   = r_fill;
        n_total  = r_total;
        n_rnd    = r_rnd;
        n_widx   = r_widx;
        n_ovalid = r_ovalid;
        n_h      = r_h;
        n_w      = r_w;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_d      = r_d;
        n_e      = r_e;
        n_len    = r_len;
        n_out    = r_out;
        wr_en    = 1'b0;
        wr_byte  = 8'h00;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    wr_en = 1'b1;
                    if (i_in.action == ACT_ABSORB) begin
                        wr_byte = i_in.data_byte;
                        n_total = r_total + 61'd1;
                        n_ret   = ST_IDLE;
                    end else begin
                        wr_byte = PAD_MARK;
                        n_len   = {r_total, 3'b000};
                        n_ret   = ST_PAD;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_fill == LEN_POS) begin
                    n_state = ST_LEN;
                end else begin
                    wr_en   = 1'b1;
                    wr_byte = 8'h00;
                    n_ret   = ST_PAD;
                end
            end
            ST_LEN: begin
                wr_en   = 1'b1;
                wr_byte = r_len[63:56];
                n_len   = {r_len[55:0], 8'h00};
                n_ret   = ST_OUT;
            end
            ST_START: begin
                n_a   = r_h[0];
                n_b   = r_h[1];
                n_c   = r_h[2];
                n_d   = r_h[3];
                n_e   = r_h[4];
                n_rnd = '0;
                n_state = ST_COMP;
            end
            ST_COMP: begin
                n_a = t_val;
                n_b = r_a;
                n_c = {r_b[1:0], r_b[31:2]};
                n_d = r_c;
                n_e = r_d;
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i + 1];
                end
                n_w[15] = w_new;
                n_rnd   = r_rnd + 7'd1;
                if (r_rnd == LAST_ROUND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_h[0]  = r_h[0] + r_a;
                n_h[1]  = r_h[1] + r_b;
                n_h[2]  = r_h[2] + r_c;
                n_h[3]  = r_h[3] + r_d;
                n_h[4]  = r_h[4] + r_e;
                n_state = r_ret;
            end
            ST_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid          = 1'b1;
                    n_out.digest_word = r_h[r_widx];
                    n_out.word_index  = r_widx;
                    n_out.last_word   = (r_widx == LAST_WORD);
                    if (r_widx == LAST_WORD) begin
                        n_widx  = '0;
                        n_h     = IV;
                        n_fill  = '0;
                        n_total = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (wr_en) begin
            n_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] = wr_byte;
            n_fill = r_fill + 6'd1;
            if (r_fill == LAST_POS) begin
                n_state = ST_START;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_fill   <= '0;
            r_total  <= '0;
            r_rnd    <= '0;
            r_widx   <= '0;
            r_ovalid <= 1'b0;
            r_h      <= IV;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_fill   <= n_fill;
            r_total  <= n_total;
            r_rnd    <= n_rnd;
            r_widx   <= n_widx;
            r_ovalid <= n_ovalid;
            r_h      <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
        r_len <= n_len;
        r_out <= n_out;
    end

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last_word == (o_out.word_index == LAST_WORD)))
        else $error("last_word does not match word_index");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP) |-> (r_rnd <= LAST_ROUND))
        else $error("round counter out of range");

    a_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN) |-> (r_fill[5:3] == 3'b111))
        else $error("length bytes written outside the last eight slots");

    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.action == ACT_FINISH) |=> !o_in_ready)
        else $error("input accepted right after a finish");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.last_word && $past(i_rst_n)) |=>
        (!o_out_valid || o_out.word_index == $past(o_out.word_index) + 3'd1))
        else $error("digest words out of order");

endmodule
